// File: sv/gmbu_pkg.sv
// gmbu_pkg: shared constants and types of the gaussian mixture background update unit
// no dependencies; used by gmbu_div and the top level

package gmbu_pkg;

    localparam int MIXTURES  = 3;
    localparam int CAP       = (MIXTURES < 3) ? MIXTURES : 3;
    localparam int SLOTS     = 3;
    localparam int DIV_STEPS = 16;
    localparam int DIV_W     = 19;

    typedef enum logic [2:0] {
        CFG_LEARNING_RATE  = 3'd0,
        CFG_BG_WEIGHT_THR  = 3'd1,
        CFG_BG_DIST_THR    = 3'd2,
        CFG_MATCH_DIST_THR = 3'd3,
        CFG_INIT_VAR       = 3'd4,
        CFG_MIN_VAR        = 3'd5,
        CFG_MAX_VAR        = 3'd6,
        CFG_PRUNE          = 3'd7
    } cfg_index_t;

    typedef logic [61:0] mode_word_t;

endpackage

// File: sv/gaussian_mixture_background_update_unit.sv
// gaussian_mixture_background_update_unit: per-pixel mixture-of-gaussians model update
// depends on gmbu_pkg and gmbu_div
//
//   channel   handshake                   payload
//   cfg       cfg_valid / cfg_ready       cfg_index, cfg_data
//   pixel     pixel_valid / pixel_stall   red, green, blue, mode_a..c, modes_in_use, sideband
//   result    result_valid / result_stall foreground, new_mode_a..c, new_modes_in_use, sideband
//
// one pixel per cycle unless a held result stalls it; stages: input, decay/distance products, compares,
// mode scan, 16 divider stages, correction products, final ordering and packing
// reset clears the valid bits and loads the register defaults
// a held result freezes the whole pipeline, and pixel_stall follows it in the same cycle

module gaussian_mixture_background_update_unit
    import gmbu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [61:0] mode_a,
    input  logic [61:0] mode_b,
    input  logic [61:0] mode_c,
    input  logic [1:0]  modes_in_use,
    input  logic        line_end,
    input  logic        frame_start,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        foreground,
    output logic [61:0] new_mode_a,
    output logic [61:0] new_mode_b,
    output logic [61:0] new_mode_c,
    output logic [1:0]  new_modes_in_use,
    output logic        line_end_out,
    output logic        frame_start_out
);

    typedef struct packed {
        logic                   fg;
        logic                   fit;
        logic [1:0]             f;
        logic [1:0]             p;
        logic [1:0]             nm;
        logic [SLOTS-1:0][16:0] wv;
        logic [SLOTS-1:0]       rdo;
        logic [SLOTS-1:0]       rsat;
        logic                   kz;
        logic                   ksat;
        logic [SLOTS-1:0][61:0] mode;
        logic [2:0][7:0]        px;
        logic [2:0][10:0]       dm;
        logic [21:0]            dist2;
        logic                   le;
        logic                   fs;
    } ctx_t;

    // configuration registers
    logic [15:0] lr_reg, bgw_reg, bgd_reg, mdt_reg, ivar_reg, vmin_reg, vmax_reg, prune_reg;
    logic [16:0] alpha1;
    logic        en;

    assign cfg_ready = 1'b1;
    assign alpha1    = 17'd65536 - {1'b0, lr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg    <= 16'd655;
            bgw_reg   <= 16'd58982;
            bgd_reg   <= 16'd9216;
            mdt_reg   <= 16'd2304;
            ivar_reg  <= 16'd3840;
            vmin_reg  <= 16'd1024;
            vmax_reg  <= 16'd19200;
            prune_reg <= 16'd33;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_LEARNING_RATE:  lr_reg    <= cfg_data;
                CFG_BG_WEIGHT_THR:  bgw_reg   <= cfg_data;
                CFG_BG_DIST_THR:    bgd_reg   <= cfg_data;
                CFG_MATCH_DIST_THR: mdt_reg   <= cfg_data;
                CFG_INIT_VAR:       ivar_reg  <= cfg_data;
                CFG_MIN_VAR:        vmin_reg  <= cfg_data;
                CFG_MAX_VAR:        vmax_reg  <= cfg_data;
                CFG_PRUNE:          prune_reg <= cfg_data;
                default:            lr_reg    <= lr_reg;
            endcase
        end
    end

    // pipeline valid bits
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, m_valid_reg, n_valid_reg;
    logic e_valid_reg [DIV_STEPS];

    assign en           = ~(n_valid_reg & result_stall);
    assign pixel_stall  = ~en;
    assign result_valid = n_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            n_valid_reg <= 1'b0;
            for (int s = 0; s < DIV_STEPS; s++)
                e_valid_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg    <= pixel_valid;
            b_valid_reg    <= a_valid_reg;
            c_valid_reg    <= b_valid_reg;
            d_valid_reg    <= c_valid_reg;
            e_valid_reg[0] <= d_valid_reg;
            for (int s = 1; s < DIV_STEPS; s++)
                e_valid_reg[s] <= e_valid_reg[s-1];
            m_valid_reg    <= e_valid_reg[DIV_STEPS-1];
            n_valid_reg    <= m_valid_reg;
        end
    end

    // stage a: input capture
    logic [7:0]  a_px_reg   [3];
    logic [61:0] a_mode_reg [SLOTS];
    logic [1:0]  a_nm_reg;
    logic        a_le_reg, a_fs_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_px_reg[0]   <= red;
            a_px_reg[1]   <= green;
            a_px_reg[2]   <= blue;
            a_mode_reg[0] <= mode_a;
            a_mode_reg[1] <= mode_b;
            a_mode_reg[2] <= mode_c;
            a_nm_reg      <= (32'(modes_in_use) > CAP) ? 2'(CAP) : modes_in_use;
            a_le_reg      <= line_end;
            a_fs_reg      <= frame_start;
        end
    end

    // stage b: weight decay and distance products
    logic signed [10:0] b_d   [SLOTS][3];
    logic signed [21:0] b_sqf [SLOTS][3];
    logic [32:0]        b_decf [SLOTS];
    logic [31:0]        b_tbgf [SLOTS];
    logic [31:0]        b_tmf  [SLOTS];

    logic signed [10:0] b_d_reg    [SLOTS][3];
    logic [19:0]        b_sq_reg   [SLOTS][3];
    logic [15:0]        b_dec_reg  [SLOTS];
    logic [31:0]        b_tbg_reg  [SLOTS];
    logic [31:0]        b_tm_reg   [SLOTS];
    logic [61:0]        b_mode_reg [SLOTS];
    logic [7:0]         b_px_reg   [3];
    logic [1:0]         b_nm_reg;
    logic               b_le_reg, b_fs_reg;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                b_d[i][c]   = $signed({1'b0, a_mode_reg[i][10*c +: 10]})
                            - $signed({1'b0, a_px_reg[c], 2'b00});
                b_sqf[i][c] = 22'(b_d[i][c]) * 22'(b_d[i][c]);
            end
            b_decf[i] = 33'(alpha1) * 33'(a_mode_reg[i][61:46]);
            b_tbgf[i] = 32'(bgd_reg) * 32'(a_mode_reg[i][45:30]);
            b_tmf[i]  = 32'(mdt_reg) * 32'(a_mode_reg[i][45:30]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    b_d_reg[i][c]  <= b_d[i][c];
                    b_sq_reg[i][c] <= b_sqf[i][c][19:0];
                end
                b_dec_reg[i]  <= b_decf[i][31:16];
                b_tbg_reg[i]  <= b_tbgf[i];
                b_tm_reg[i]   <= b_tmf[i];
                b_mode_reg[i] <= a_mode_reg[i];
            end
            for (int c = 0; c < 3; c++)
                b_px_reg[c] <= a_px_reg[c];
            b_nm_reg <= a_nm_reg;
            b_le_reg <= a_le_reg;
            b_fs_reg <= a_fs_reg;
        end
    end

    // stage c: decayed weights and match / background compares
    logic [21:0]        c_dist2 [SLOTS];
    logic signed [17:0] c_dw_reg    [SLOTS];
    logic signed [17:0] c_dm_reg    [SLOTS];
    logic [21:0]        c_dist2_reg [SLOTS];
    logic               c_match_reg [SLOTS];
    logic               c_bgd_reg   [SLOTS];
    logic signed [10:0] c_d_reg     [SLOTS][3];
    logic [61:0]        c_mode_reg  [SLOTS];
    logic [7:0]         c_px_reg    [3];
    logic [1:0]         c_nm_reg;
    logic               c_le_reg, c_fs_reg;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
            c_dist2[i] = 22'(b_sq_reg[i][0]) + 22'(b_sq_reg[i][1]) + 22'(b_sq_reg[i][2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                c_dw_reg[i]    <= $signed({2'b00, b_dec_reg[i]}) - $signed({2'b00, prune_reg});
                c_dm_reg[i]    <= $signed({2'b00, b_dec_reg[i]}) - $signed({2'b00, prune_reg})
                                + $signed({2'b00, lr_reg});
                c_dist2_reg[i] <= c_dist2[i];
                c_match_reg[i] <= {c_dist2[i], 12'b0} < {2'b00, b_tm_reg[i]};
                c_bgd_reg[i]   <= {c_dist2[i], 12'b0} < {2'b00, b_tbg_reg[i]};
                for (int c = 0; c < 3; c++)
                    c_d_reg[i][c] <= b_d_reg[i][c];
                c_mode_reg[i]  <= b_mode_reg[i];
            end
            for (int c = 0; c < 3; c++)
                c_px_reg[c] <= b_px_reg[c];
            c_nm_reg <= b_nm_reg;
            c_le_reg <= b_le_reg;
            c_fs_reg <= b_fs_reg;
        end
    end

    // stage d: in-order scan over the modes, bubble of the matched mode, pruning
    logic [1:0]         nm_s, f_s, p_s, sc, pos;
    logic               fit_s, bg_s, kz_s, ksat_s;
    logic [18:0]        total_s;
    logic signed [18:0] w_s;
    logic signed [17:0] wm_s;
    logic [16:0]        wv_s [SLOTS];
    ctx_t               d_ctx;

    ctx_t               d_ctx_reg;
    logic [DIV_W-1:0]   d_kx_reg, d_kd_reg, d_rd_reg;
    logic [DIV_W-1:0]   d_rx_reg [SLOTS];

    always_comb
    begin
        nm_s    = c_nm_reg;
        fit_s   = 1'b0;
        bg_s    = 1'b0;
        total_s = '0;
        f_s     = '0;
        p_s     = '0;
        wm_s    = '0;
        sc      = '0;
        pos     = '0;
        w_s     = '0;
        for (int s = 0; s < SLOTS; s++)
            wv_s[s] = {1'b0, c_mode_reg[s][61:46]};
        for (int i = 0; i < SLOTS; i++)
        begin
            if (2'(i) < nm_s)
            begin
                w_s = 19'(c_dw_reg[i]);
                sc  = '0;
                if (!fit_s)
                begin
                    if (total_s < {3'b000, bgw_reg} && c_bgd_reg[i])
                        bg_s = 1'b1;
                    if (c_match_reg[i])
                    begin
                        fit_s = 1'b1;
                        f_s   = 2'(i);
                        w_s   = 19'(c_dm_reg[i]);
                        wm_s  = c_dm_reg[i];
                        if (i == 1)
                        begin
                            if (w_s >= $signed({2'b00, wv_s[0]}))
                                sc = 2'd1;
                        end
                        else if (i == 2)
                        begin
                            if (w_s >= $signed({2'b00, wv_s[1]}))
                                sc = (w_s >= $signed({2'b00, wv_s[0]})) ? 2'd2 : 2'd1;
                        end
                        p_s = 2'(i) - sc;
                    end
                end
                if (w_s < $signed({3'b000, prune_reg}))
                begin
                    w_s  = '0;
                    nm_s = nm_s - 2'd1;
                end
                // earlier modes move down one slot under the bubbled one
                for (int j = SLOTS - 1; j > 0; j--)
                begin
                    if (j <= i && j > i - int'(sc))
                        wv_s[j] = wv_s[j-1];
                end
                pos       = 2'(i) - sc;
                wv_s[pos] = w_s[16:0];
                total_s   = total_s + {2'b00, w_s[16:0]};
            end
        end

        kz_s   = (wm_s <= 18'sd0);
        ksat_s = !kz_s && ($signed({2'b00, lr_reg}) >= wm_s);

        d_ctx.fg   = ~bg_s;
        d_ctx.fit  = fit_s;
        d_ctx.f    = f_s;
        d_ctx.p    = p_s;
        d_ctx.nm   = nm_s;
        d_ctx.kz   = kz_s;
        d_ctx.ksat = ksat_s;
        for (int s = 0; s < SLOTS; s++)
        begin
            d_ctx.wv[s]   = wv_s[s];
            d_ctx.rdo[s]  = (total_s != '0) && (2'(s) < nm_s);
            d_ctx.rsat[s] = {2'b00, wv_s[s]} >= total_s;
            d_ctx.mode[s] = c_mode_reg[s];
        end
        for (int c = 0; c < 3; c++)
        begin
            d_ctx.px[c] = c_px_reg[c];
            d_ctx.dm[c] = c_d_reg[f_s][c];
        end
        d_ctx.dist2 = c_dist2_reg[f_s];
        d_ctx.le    = c_le_reg;
        d_ctx.fs    = c_fs_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_ctx_reg <= d_ctx;
            d_kx_reg  <= (kz_s || ksat_s) ? '0 : {3'b000, lr_reg};
            d_kd_reg  <= kz_s ? 19'd1 : {2'b00, wm_s[16:0]};
            d_rd_reg  <= (total_s == '0) ? 19'd1 : total_s;
            for (int s = 0; s < SLOTS; s++)
                d_rx_reg[s] <= (d_ctx.rdo[s] && !d_ctx.rsat[s]) ? {2'b00, wv_s[s]} : '0;
        end
    end

    // divider stages: gain for the matched mode and the three renormalized weights
    logic [DIV_STEPS-1:0] q_k;
    logic [DIV_STEPS-1:0] q_r [SLOTS];
    ctx_t                 e_ctx_reg [DIV_STEPS];

    gmbu_div u_div_k
    (
        .clk (clk),
        .en  (en),
        .x   (d_kx_reg),
        .d   (d_kd_reg),
        .q   (q_k)
    );

    for (genvar s = 0; s < SLOTS; s++)
    begin : g_norm
        gmbu_div u_div_r
        (
            .clk (clk),
            .en  (en),
            .x   (d_rx_reg[s]),
            .d   (d_rd_reg),
            .q   (q_r[s])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_ctx_reg[0] <= d_ctx_reg;
            for (int s = 1; s < DIV_STEPS; s++)
                e_ctx_reg[s] <= e_ctx_reg[s-1];
        end
    end

    // stage m: correction products and new-mode rescale products
    ctx_t               ectx;
    logic [15:0]        k;
    logic [15:0]        vf;
    logic signed [26:0] diffv;
    logic [16:0]        wr    [SLOTS];
    logic [33:0]        rescf [SLOTS];

    ctx_t               m_ctx_reg;
    logic signed [27:0] m_pmu_reg [3];
    logic signed [43:0] m_pv_reg;
    logic [16:0]        m_wr_reg   [SLOTS];
    logic [16:0]        m_resc_reg [SLOTS];

    always_comb
    begin
        ectx  = e_ctx_reg[DIV_STEPS-1];
        k     = ectx.kz ? 16'd0 : (ectx.ksat ? 16'hFFFF : q_k);
        vf    = ectx.mode[ectx.f][45:30];
        diffv = $signed({1'b0, ectx.dist2, 4'b0000}) - $signed({11'b0, vf});
        for (int s = 0; s < SLOTS; s++)
        begin
            wr[s]    = ectx.rdo[s] ? (ectx.rsat[s] ? 17'd65535 : {1'b0, q_r[s]}) : ectx.wv[s];
            rescf[s] = 34'(wr[s]) * 34'(alpha1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_ctx_reg <= ectx;
            for (int c = 0; c < 3; c++)
                m_pmu_reg[c] <= 28'($signed({1'b0, k})) * 28'($signed(ectx.dm[c]));
            m_pv_reg <= 44'($signed({1'b0, k})) * 44'(diffv);
            for (int s = 0; s < SLOTS; s++)
            begin
                m_wr_reg[s]   <= wr[s];
                m_resc_reg[s] <= rescf[s][32:16];
            end
        end
    end

    // stage n: rounding and clamps, slot order, new mode, packing
    logic signed [12:0] rmu [3];
    logic signed [13:0] mun [3];
    logic [9:0]         mu_upd [3];
    logic signed [28:0] rv;
    logic signed [29:0] vn;
    logic [15:0]        v_upd;
    logic [15:0]        vm;
    logic [1:0]         src, nm_a, nm_b, idx;
    logic [16:0]        nw  [SLOTS];
    logic [15:0]        nv  [SLOTS];
    logic [9:0]         nmu [SLOTS][3];
    logic [16:0]        tw;
    logic [15:0]        tv;
    logic [9:0]         tmu [3];
    logic               stop;
    logic [61:0]        n_mode [SLOTS];

    logic               n_fg_reg, n_le_reg, n_fs_reg;
    logic [61:0]        n_mode_reg [SLOTS];
    logic [1:0]         n_nm_reg;

    always_comb
    begin
        vm = m_ctx_reg.mode[m_ctx_reg.f][45:30];
        for (int c = 0; c < 3; c++)
        begin
            rmu[c] = 13'((29'(m_pmu_reg[c]) + 29'sd32768) >>> 16);
            mun[c] = $signed({4'b0000, m_ctx_reg.mode[m_ctx_reg.f][10*c +: 10]}) - 14'(rmu[c]);
            if (mun[c] < 14'sd0)
                mu_upd[c] = 10'd0;
            else if (mun[c] > 14'sd1023)
                mu_upd[c] = 10'd1023;
            else
                mu_upd[c] = mun[c][9:0];
        end
        rv = 29'((45'(m_pv_reg) + 45'sd32768) >>> 16);
        vn = $signed({14'b0, vm}) + 30'(rv);
        if (vn < $signed({14'b0, vmin_reg}))
            vn = $signed({14'b0, vmin_reg});
        if (vn > $signed({14'b0, vmax_reg}))
            vn = $signed({14'b0, vmax_reg});
        v_upd = vn[15:0];

        // slot order left by the scan
        for (int s = 0; s < SLOTS; s++)
        begin
            if (m_ctx_reg.fit && 2'(s) == m_ctx_reg.p)
                src = m_ctx_reg.f;
            else if (m_ctx_reg.fit && 2'(s) > m_ctx_reg.p && 2'(s) <= m_ctx_reg.f)
                src = 2'(s) - 2'd1;
            else
                src = 2'(s);
            nw[s] = m_wr_reg[s];
            if (m_ctx_reg.fit && 2'(s) == m_ctx_reg.p)
            begin
                nv[s] = v_upd;
                for (int c = 0; c < 3; c++)
                    nmu[s][c] = mu_upd[c];
            end
            else
            begin
                nv[s] = m_ctx_reg.mode[src][45:30];
                for (int c = 0; c < 3; c++)
                    nmu[s][c] = m_ctx_reg.mode[src][10*c +: 10];
            end
        end

        // no match and a nonzero learning rate: replace the weakest mode or add one
        nm_a = m_ctx_reg.nm;
        nm_b = nm_a;
        idx  = '0;
        stop = 1'b0;
        tw   = '0;
        tv   = '0;
        for (int c = 0; c < 3; c++)
            tmu[c] = '0;
        if (!m_ctx_reg.fit && lr_reg != 16'd0)
        begin
            if (32'(nm_a) == CAP)
            begin
                idx  = 2'(CAP - 1);
                nm_b = nm_a;
            end
            else
            begin
                idx  = nm_a;
                nm_b = nm_a + 2'd1;
            end
            if (nm_b == 2'd1)
                nw[idx] = 17'd65535;
            else
            begin
                nw[idx] = {1'b0, lr_reg};
                for (int j = 0; j < SLOTS; j++)
                begin
                    if (2'(j) < nm_b - 2'd1)
                        nw[j] = m_resc_reg[j];
                end
            end
            nv[idx] = ivar_reg;
            for (int c = 0; c < 3; c++)
                nmu[idx][c] = {m_ctx_reg.px[c], 2'b00};
            for (int j = SLOTS - 1; j > 0; j--)
            begin
                if (!stop && 2'(j) < nm_b)
                begin
                    if ({1'b0, lr_reg} < nw[j-1])
                        stop = 1'b1;
                    else
                    begin
                        tw      = nw[j];
                        nw[j]   = nw[j-1];
                        nw[j-1] = tw;
                        tv      = nv[j];
                        nv[j]   = nv[j-1];
                        nv[j-1] = tv;
                        for (int c = 0; c < 3; c++)
                        begin
                            tmu[c]      = nmu[j][c];
                            nmu[j][c]   = nmu[j-1][c];
                            nmu[j-1][c] = tmu[c];
                        end
                    end
                end
            end
        end

        for (int s = 0; s < SLOTS; s++)
            n_mode[s] = {(nw[s][16] ? 16'hFFFF : nw[s][15:0]), nv[s],
                         nmu[s][2], nmu[s][1], nmu[s][0]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_fg_reg <= m_ctx_reg.fg;
            for (int s = 0; s < SLOTS; s++)
                n_mode_reg[s] <= n_mode[s];
            n_nm_reg <= nm_b;
            n_le_reg <= m_ctx_reg.le;
            n_fs_reg <= m_ctx_reg.fs;
        end
    end

    assign foreground       = n_fg_reg;
    assign new_mode_a       = n_mode_reg[0];
    assign new_mode_b       = n_mode_reg[1];
    assign new_mode_c       = n_mode_reg[2];
    assign new_modes_in_use = n_nm_reg;
    assign line_end_out     = n_le_reg;
    assign frame_start_out  = n_fs_reg;

endmodule

// File: sv/gmbu_div.sv
// gmbu_div: pipelined restoring divider, (x * 2^16) / d with x < d, one quotient bit per stage
// depends on gmbu_pkg

module gmbu_div
    import gmbu_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [DIV_W-1:0]     x,
    input  logic [DIV_W-1:0]     d,
    output logic [DIV_STEPS-1:0] q
);

    logic [DIV_W-1:0]     r_reg  [DIV_STEPS];
    logic [DIV_W-1:0]     d_reg  [DIV_STEPS];
    logic [DIV_STEPS-1:0] q_reg  [DIV_STEPS];
    logic [DIV_W-1:0]     r_next [DIV_STEPS];
    logic [DIV_STEPS-1:0] q_next [DIV_STEPS];

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_step
        logic [DIV_W-1:0]     r_in;
        logic [DIV_W-1:0]     d_in;
        logic [DIV_STEPS-1:0] q_in;
        logic [DIV_W:0]       r2;

        if (s == 0)
        begin : g_first
            assign r_in = x;
            assign d_in = d;
            assign q_in = '0;
        end
        else
        begin : g_rest
            assign r_in = r_reg[s-1];
            assign d_in = d_reg[s-1];
            assign q_in = q_reg[s-1];
        end

        // dividend low bits are all zero, so each step only doubles the remainder
        assign r2 = {r_in, 1'b0};

        always_comb
        begin
            if (r2 >= {1'b0, d_in})
            begin
                r_next[s] = DIV_W'(r2 - {1'b0, d_in});
                q_next[s] = {q_in[DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                r_next[s] = r2[DIV_W-1:0];
                q_next[s] = {q_in[DIV_STEPS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[s] <= r_next[s];
                d_reg[s] <= d_in;
                q_reg[s] <= q_next[s];
            end
        end
    end

    assign q = q_reg[DIV_STEPS-1];

endmodule
